@@ rtl/rclp_pkg.sv @@
// ----------------------------------------------------------------------------
// rclp_pkg: shared types and constants of the radiation count line parser
// Holds the item structs, the result and status codes and the character
// constants that the parser core and the top level use.
// ----------------------------------------------------------------------------
package rclp_pkg;

  // Item kinds on the input channel.
  localparam logic OpByte = 1'b0;
  localparam logic OpTick = 1'b1;

  // Parse result codes.
  typedef enum logic [1:0] {
    PrIncomplete = 2'd0,
    PrComplete   = 2'd1,
    PrParseError = 2'd2,
    PrOverrun    = 2'd3
  } parse_result_e;

  // Reported status codes.
  typedef enum logic [1:0] {
    StInit    = 2'd0,
    StValid   = 2'd1,
    StInvalid = 2'd2,
    StError   = 2'd3
  } status_e;

  // Characters that the parser looks for.
  localparam logic [7:0] CharC  = 8'h43;
  localparam logic [7:0] CharV  = 8'h56;
  localparam logic [7:0] CharCr = 8'h0D;
  localparam logic [7:0] CharLf = 8'h0A;
  localparam logic [7:0] Char0  = 8'h30;
  localparam logic [7:0] Char9  = 8'h39;

  // Length of the line head "CPM:1:".
  localparam int unsigned HeadLen = 6;

  // Count limits and register reset values.
  localparam logic [26:0] CpmSat       = 27'd99999999;
  localparam logic [26:0] CpmReset     = 27'd999999;
  localparam logic [15:0] TimeoutReset = 16'd4000;

  // Configuration register indexes.
  localparam logic RegTimeout = 1'b0;

  // One input transaction.
  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_byte;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    parse_result_e parse_result;
    logic [26:0]   reading_cpm;
    status_e       status;
    logic          timed_out;
  } out_item_t;

  // Expected character at a position of the line head "CPM:1:".
  function automatic logic [7:0] head_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h43;
      3'd1:    ch = 8'h50;
      3'd2:    ch = 8'h4D;
      3'd3:    ch = 8'h3A;
      3'd4:    ch = 8'h31;
      3'd5:    ch = 8'h3A;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/radiation_count_line_parser.sv @@
// ----------------------------------------------------------------------------
// radiation_count_line_parser: serial counter line parser
// Parses "CPM:1:<digits>...V<CR><LF>" lines from a byte stream, tracks time
// ticks, and reports the last count with a status per transaction.
// ----------------------------------------------------------------------------
// The block takes one input transaction per clock cycle while the output is
// not stalled and returns one result for each in the cycle after acceptance.
// A single result register separates the two channels; it is refilled in
// the same cycle in which its result is taken, so a stalled output holds at
// most one result and back-to-back transactions pass at full rate. The
// timeout register is written through the APB-style port at byte address 0.
module radiation_count_line_parser import rclp_pkg::*; #(
  parameter int unsigned BUFFER_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        accept;
  logic [15:0] timeout_ticks;
  out_item_t   result;
  out_item_t   out_item_q;
  logic        out_valid_q;

  // Configuration registers.
  rclp_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .timeout_ticks_o (timeout_ticks)
  );

  // Parser core.
  rclp_parser #(
    .BUFFER_LENGTH (BUFFER_LENGTH)
  ) u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (accept),
    .item_i          (in_item_i),
    .timeout_ticks_i (timeout_ticks),
    .result_o        (result)
  );

  // Accept whenever the result register is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/rclp_apb_regs.sv @@
// ----------------------------------------------------------------------------
// rclp_apb_regs: configuration registers of the line parser
// APB-style slave holding the timeout register. Writes complete in the
// access phase; reads return the register value, zero elsewhere.
// ----------------------------------------------------------------------------
module rclp_apb_regs import rclp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] timeout_ticks_o
);

  logic [15:0] timeout_q;
  logic        wr_en;

  // The slave never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == RegTimeout);

  // Timeout register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (wr_en) begin
      timeout_q <= pwdata[15:0];
    end
  end

  // Read data.
  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == RegTimeout) begin
      prdata = {16'd0, timeout_q};
    end
  end

  assign timeout_ticks_o = timeout_q;

endmodule

@@ rtl/rclp_parser.sv @@
// ----------------------------------------------------------------------------
// rclp_parser: line parser state and per-item update
// Keeps the line tracking flags, the prefix matcher, the decimal
// accumulator and the tick counter, and works out one result per item.
// ----------------------------------------------------------------------------
module rclp_parser import rclp_pkg::*; #(
  parameter int unsigned BUFFER_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  in_item_t    item_i,
  input  logic [15:0] timeout_ticks_i,
  output out_item_t   result_o
);

  localparam int unsigned CntW = $clog2(BUFFER_LENGTH + 1);
  localparam logic [CntW-1:0] BufLen  = CntW'(BUFFER_LENGTH);
  localparam logic [CntW-1:0] HeadEnd = CntW'(HeadLen);

  logic            in_line_q, in_line_d;
  logic            saw_cr_q, saw_cr_d;
  logic [CntW-1:0] byte_count_q, byte_count_d;
  logic            prefix_ok_q, prefix_ok_d;
  logic            digits_open_q, digits_open_d;
  logic [26:0]     digit_acc_q, digit_acc_d;
  logic [7:0]      prev_byte_q, prev_byte_d;
  logic [26:0]     held_cpm_q, held_cpm_d;
  status_e         held_status_q, held_status_d;
  logic [15:0]     elapsed_q, elapsed_d;

  // Line state as seen by the current byte, after an opening 'C'.
  logic            opening;
  logic            cur_cr;
  logic [CntW-1:0] cur_count;
  logic            cur_pok;
  logic            cur_dopen;
  logic [26:0]     cur_acc;
  logic [7:0]      ch;
  logic            is_digit;
  logic [30:0]     acc_next;
  parse_result_e   result;
  logic            tmo;

  assign ch       = item_i.rx_byte;
  assign is_digit = (ch >= Char0) && (ch <= Char9);
  assign opening  = !in_line_q;

  assign cur_cr    = opening ? 1'b0 : saw_cr_q;
  assign cur_count = opening ? '0 : byte_count_q;
  assign cur_pok   = opening ? 1'b1 : prefix_ok_q;
  assign cur_dopen = opening ? 1'b1 : digits_open_q;
  assign cur_acc   = opening ? 27'd0 : digit_acc_q;

  // Accumulator times ten plus the new digit.
  assign acc_next = ({4'd0, cur_acc} << 3) + ({4'd0, cur_acc} << 1)
                  + {27'd0, ch[3:0] - Char0[3:0]};

  // Next state and result for one item.
  always_comb begin
    in_line_d     = in_line_q;
    saw_cr_d      = saw_cr_q;
    byte_count_d  = byte_count_q;
    prefix_ok_d   = prefix_ok_q;
    digits_open_d = digits_open_q;
    digit_acc_d   = digit_acc_q;
    prev_byte_d   = prev_byte_q;
    held_cpm_d    = held_cpm_q;
    held_status_d = held_status_q;
    elapsed_d     = elapsed_q;
    result        = PrIncomplete;
    tmo           = 1'b0;

    if (item_i.opcode == OpByte) begin
      if (!in_line_q && (ch != CharC)) begin
        // A stray byte outside a line.
        held_status_d = StError;
        result        = PrParseError;
      end else if (cur_count >= BufLen) begin
        // The line is too long: drop the byte and abandon the line.
        in_line_d     = 1'b0;
        saw_cr_d      = 1'b0;
        byte_count_d  = '0;
        held_status_d = StError;
        result        = PrOverrun;
      end else begin
        in_line_d     = 1'b1;
        byte_count_d  = cur_count + 1'b1;
        prefix_ok_d   = cur_pok;
        digits_open_d = cur_dopen;
        digit_acc_d   = cur_acc;

        // Prefix match over the head, then digit collection.
        if (cur_count < HeadEnd) begin
          if (ch != head_char(cur_count[2:0])) begin
            prefix_ok_d = 1'b0;
          end
        end else if (cur_dopen) begin
          if (is_digit) begin
            if (acc_next > {4'd0, CpmSat}) begin
              digit_acc_d = CpmSat;
            end else begin
              digit_acc_d = acc_next[26:0];
            end
          end else begin
            digits_open_d = 1'b0;
          end
        end

        // End of line detection.
        if (!cur_cr && (ch == CharCr)) begin
          saw_cr_d = 1'b1;
        end else if (cur_cr && (ch != CharLf)) begin
          saw_cr_d    = 1'b0;
          prev_byte_d = ch;
        end else if (cur_cr) begin
          in_line_d    = 1'b0;
          saw_cr_d     = 1'b0;
          byte_count_d = '0;
          if (prefix_ok_d) begin
            held_cpm_d    = digit_acc_d;
            held_status_d = (prev_byte_q == CharV) ? StValid : StInvalid;
            elapsed_d     = 16'd0;
            result        = PrComplete;
          end
        end else begin
          saw_cr_d    = 1'b0;
          prev_byte_d = ch;
        end
      end
    end else begin
      // Time tick: saturating count and timeout check.
      if (elapsed_q != 16'hFFFF) begin
        elapsed_d = elapsed_q + 16'd1;
      end
      if (elapsed_d >= timeout_ticks_i) begin
        held_status_d = StError;
        tmo           = 1'b1;
      end
    end
  end

  // State registers, updated once per accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_line_q     <= 1'b0;
      saw_cr_q      <= 1'b0;
      byte_count_q  <= '0;
      prefix_ok_q   <= 1'b1;
      digits_open_q <= 1'b1;
      digit_acc_q   <= 27'd0;
      prev_byte_q   <= 8'd0;
      held_cpm_q    <= CpmReset;
      held_status_q <= StInit;
      elapsed_q     <= 16'd0;
    end else if (step_i) begin
      in_line_q     <= in_line_d;
      saw_cr_q      <= saw_cr_d;
      byte_count_q  <= byte_count_d;
      prefix_ok_q   <= prefix_ok_d;
      digits_open_q <= digits_open_d;
      digit_acc_q   <= digit_acc_d;
      prev_byte_q   <= prev_byte_d;
      held_cpm_q    <= held_cpm_d;
      held_status_q <= held_status_d;
      elapsed_q     <= elapsed_d;
    end
  end

  // Result of the current item.
  assign result_o.parse_result = result;
  assign result_o.reading_cpm  = held_cpm_d;
  assign result_o.status       = held_status_d;
  assign result_o.timed_out    = tmo;

endmodule

@@ sim/radiation_count_line_parser_checker.sv @@
// ----------------------------------------------------------------------------
// radiation_count_line_parser_checker: result checker of the line parser
// Watches the input, result and configuration channels of the parser, keeps
// its own model of the parser state, and compares every result transaction
// field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module radiation_count_line_parser_checker import rclp_pkg::*; #(
  parameter int unsigned BUFFER_LENGTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          mismatches_o,
  output int          reports_due_o
);

  // The line head, first character in the top byte.
  localparam logic [47:0] LineHead = "CPM:1:";
  localparam logic [2:0]  TimeoutAddr = {RegTimeout, 2'b00};

  // Model of the parser state and of the timeout register.
  logic [15:0] timeout_ticks;
  logic        in_line;
  logic        saw_cr;
  logic [4:0]  byte_count;
  logic        prefix_ok;
  logic        digits_open;
  logic [26:0] digit_acc;
  logic [7:0]  prev_byte;
  logic [26:0] held_cpm;
  status_e     held_status;
  logic [15:0] elapsed_ticks;

  out_item_t   pending_reports[$];
  int          mismatches = 0;

  initial begin
    mismatches_o  = 0;
    reports_due_o = 0;
  end

  task automatic reset_parser();
    timeout_ticks = TimeoutReset;
    in_line       = 1'b0;
    saw_cr        = 1'b0;
    byte_count    = '0;
    prefix_ok     = 1'b1;
    digits_open   = 1'b1;
    digit_acc     = '0;
    prev_byte     = '0;
    held_cpm      = CpmReset;
    held_status   = StInit;
    elapsed_ticks = '0;
  endtask

  // Applies one input transaction to the model and builds the report it causes.
  task automatic advance_parser(input in_item_t item, output out_item_t report);
    parse_result_e verdict;
    logic          tmo;
    logic [7:0]    ch;
    logic [4:0]    pos;
    int unsigned   digit;
    verdict = PrIncomplete;
    tmo     = 1'b0;
    ch      = item.rx_byte;
    if (item.opcode == OpByte) begin
      if (!in_line && ch != CharC) begin
        // A stray byte outside a line.
        held_status = StError;
        verdict     = PrParseError;
      end else begin
        if (!in_line) begin
          in_line     = 1'b1;
          saw_cr      = 1'b0;
          byte_count  = '0;
          prefix_ok   = 1'b1;
          digits_open = 1'b1;
          digit_acc   = '0;
        end
        if (byte_count >= BUFFER_LENGTH) begin
          // The line is too long: drop the byte and abandon the line.
          in_line     = 1'b0;
          saw_cr      = 1'b0;
          byte_count  = '0;
          held_status = StError;
          verdict     = PrOverrun;
        end else begin
          pos        = byte_count;
          byte_count = byte_count + 5'd1;
          if (pos < HeadLen) begin
            if (ch != LineHead[8 * (HeadLen - 1 - pos) +: 8]) prefix_ok = 1'b0;
          end else if (digits_open) begin
            if (ch >= Char0 && ch <= Char9) begin
              digit = 32'(ch - Char0);
              if (digit_acc > (CpmSat - digit) / 10) begin
                digit_acc = CpmSat;
              end else begin
                digit_acc = 27'(digit_acc * 10 + digit);
              end
            end else begin
              digits_open = 1'b0;
            end
          end
          // End detection: CR arms it, LF right after closes the line.
          if (!saw_cr && ch == CharCr) begin
            saw_cr = 1'b1;
          end else if (saw_cr && ch != CharLf) begin
            saw_cr    = 1'b0;
            prev_byte = ch;
          end else if (saw_cr) begin
            in_line    = 1'b0;
            saw_cr     = 1'b0;
            byte_count = '0;
            if (prefix_ok) begin
              held_cpm      = digit_acc;
              held_status   = (prev_byte == CharV) ? StValid : StInvalid;
              elapsed_ticks = '0;
              verdict       = PrComplete;
            end
          end else begin
            prev_byte = ch;
          end
        end
      end
    end else begin
      // Time tick: saturating count, then the timeout comparison.
      if (elapsed_ticks != 16'hFFFF) elapsed_ticks = elapsed_ticks + 16'd1;
      if (elapsed_ticks >= timeout_ticks) begin
        held_status = StError;
        tmo         = 1'b1;
      end
    end
    report.parse_result = verdict;
    report.reading_cpm  = held_cpm;
    report.status       = held_status;
    report.timed_out    = tmo;
  endtask

  task automatic check_field(string name, logic [31:0] expected, logic [31:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, actual %0d", name, expected, actual);
      mismatches++;
    end
  endtask

  // Results are checked before the new input is predicted; the block never
  // returns a result in the cycle its input is accepted.
  always @(posedge clk_i) begin
    out_item_t exp_report;
    out_item_t new_report;
    if (!rst_ni) begin
      reset_parser();
      pending_reports.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_reports.size() == 0) begin
          $error("result transaction with no prediction waiting");
          mismatches++;
        end else begin
          exp_report = pending_reports.pop_front();
          check_field("parse_result", 32'(exp_report.parse_result),
                      32'(out_item_i.parse_result));
          check_field("reading_cpm", 32'(exp_report.reading_cpm),
                      32'(out_item_i.reading_cpm));
          check_field("status", 32'(exp_report.status), 32'(out_item_i.status));
          check_field("timed_out", 32'(exp_report.timed_out),
                      32'(out_item_i.timed_out));
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_parser(in_item_i, new_report);
        pending_reports.push_back(new_report);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == TimeoutAddr) begin
        timeout_ticks = pwdata_i[15:0];
      end
    end
    mismatches_o  <= mismatches;
    reports_due_o <= pending_reports.size();
  end

endmodule

@@ sim/radiation_count_line_parser_tb.sv @@
// ----------------------------------------------------------------------------
// radiation_count_line_parser_tb: testbench of the radiation count line parser
// Drives directed lines, stray bytes and ticks, then random well-formed and
// broken lines under several timeout settings and handshake idling phases.
// A checker module beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module radiation_count_line_parser_tb;
  import rclp_pkg::*;

  localparam int unsigned BufLen      = 16;
  localparam logic [2:0]  TimeoutAddr = {RegTimeout, 2'b00};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          items_sent     = 0;
  int          mismatches;
  int          reports_due;
  logic [7:0]  line_q[$];

  radiation_count_line_parser #(
    .BUFFER_LENGTH(BufLen)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  radiation_count_line_parser_checker #(
    .BUFFER_LENGTH(BufLen)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_i   (out_item_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .reports_due_o(reports_due)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver side: random stalls at the phase's rate.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Hands one transaction to the block, with a random gap before it.
  task automatic send_item(in_item_t item);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      do begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic push_text(string text);
    foreach (text[i]) line_q.push_back(text[i]);
  endtask

  task automatic send_line();
    foreach (line_q[i]) send_item(in_item_t'{opcode: OpByte, rx_byte: line_q[i]});
    line_q.delete();
  endtask

  task automatic send_tick();
    send_item(in_item_t'{opcode: OpTick, rx_byte: 8'($urandom)});
  endtask

  // Holds off the sender until every predicted result has come back.
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (reports_due != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write of the timeout register: setup cycle, then access cycle.
  task automatic write_timeout(logic [15:0] ticks);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TimeoutAddr;
    pwdata  <= {16'd0, ticks};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One random piece of traffic: ticks, noise, an overlong line or a count line.
  task automatic send_random_chunk();
    int kind;
    int nines;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      repeat ($urandom_range(1, 4)) send_tick();
    end else if (kind < 25) begin
      repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom));
      send_line();
    end else if (kind < 33) begin
      line_q.push_back(CharC);
      repeat ($urandom_range(BufLen - 2, BufLen + 2)) line_q.push_back(8'($urandom));
      send_line();
    end else begin
      push_text("CPM:1:");
      if ($urandom_range(0, 9) == 0) line_q[$urandom_range(1, HeadLen - 1)] = 8'($urandom);
      if ($urandom_range(0, 7) == 0) begin
        // Eight digits fill the line exactly; eight nines reach the count limit.
        nines = $urandom_range(0, 1);
        repeat (8) line_q.push_back(nines ? Char9 : 8'(Char0 + $urandom_range(0, 9)));
      end else begin
        case ($urandom_range(0, 9))
          0: push_text(" ");
          1: push_text("+");
          2: push_text("-");
          default: ;
        endcase
        repeat ($urandom_range(0, 5)) line_q.push_back(8'(Char0 + $urandom_range(0, 9)));
        if ($urandom_range(0, 3) == 0) line_q.push_back(8'($urandom));
        // A CR that is not followed by LF must not end the line.
        if ($urandom_range(0, 9) == 0) begin
          line_q.push_back(CharCr);
          line_q.push_back(8'($urandom));
        end
        line_q.push_back(($urandom_range(0, 3) != 0) ? CharV : 8'($urandom));
      end
      line_q.push_back(CharCr);
      line_q.push_back(CharLf);
      send_line();
    end
  endtask

  initial begin
    int target;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a tick, stray bytes at both extremes, a valid line and
    // a line without the head.
    send_tick();
    send_item(in_item_t'{opcode: OpByte, rx_byte: 8'h00});
    send_item(in_item_t'{opcode: OpByte, rx_byte: 8'hFF});
    push_text("CPM:1:7V");
    line_q.push_back(CharCr);
    line_q.push_back(CharLf);
    send_line();
    push_text("CQ");
    line_q.push_back(CharCr);
    line_q.push_back(CharLf);
    send_line();

    // A zero timeout makes every tick time out.
    drain_reports();
    write_timeout(16'd0);
    send_tick();
    send_tick();

    // Random phases with different idling and timeout settings.
    for (int phase = 0; phase < 4; phase++) begin
      drain_reports();
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          write_timeout(16'd1);
        end
        1: begin
          send_idle_pct  = 72;
          recv_stall_pct = 0;
          write_timeout(16'hFFFF);
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 72;
          write_timeout(16'($urandom_range(2, 40)));
        end
        default: begin
          send_idle_pct  = 8;
          recv_stall_pct = 8;
          write_timeout(16'($urandom_range(2, 40)));
        end
      endcase
      target = items_sent + 125;
      while (items_sent < target) begin
        send_random_chunk();
        if ($urandom_range(0, 39) == 0) drain_reports();
      end
    end

    drain_reports();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run time limit.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/rclp_pkg.sv
rtl/rclp_apb_regs.sv
rtl/rclp_parser.sv
rtl/radiation_count_line_parser.sv
sim/radiation_count_line_parser_checker.sv
sim/radiation_count_line_parser_tb.sv
